// ----- hdl/gcbci_pkg.sv -----
// Package for the grid cell bilinear coordinate interpolator.
// Shared widths, register indexes and the reciprocal scaling for the final divide.
// No dependencies.
`default_nettype none
package gcbci_pkg;
  localparam int unsigned GridMaxDefault = 8;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ExtW   = 23;
  localparam int unsigned SizeW  = 4;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned AddrW  = 3;
  // Sums reach 49 * 2^31 < 2^37, so a 37-bit scale keeps the estimate within one
  localparam int unsigned RecipShift = 37;
  localparam int unsigned RecipW     = 38;
  localparam int unsigned RecipLoW   = 19;

  typedef enum logic [0:0] {
    REG_IMAGE_LINES   = 1'b0,
    REG_IMAGE_SAMPLES = 1'b1
  } reg_idx_e;
endpackage
`default_nettype wire

// ----- hdl/gcbci_if.sv -----
// Valid/ready channel interfaces for the interpolator.
// Depends on gcbci_pkg.
`default_nettype none
interface gcbci_in_if import gcbci_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] top_left_line, top_left_sample;
  logic signed [CoordW-1:0] top_right_line, top_right_sample;
  logic signed [CoordW-1:0] bottom_left_line, bottom_left_sample;
  logic signed [CoordW-1:0] bottom_right_line, bottom_right_sample;
  logic [SizeW-1:0] cell_rows, cell_cols;
  modport source (output valid, top_left_line, top_left_sample, top_right_line,
    top_right_sample, bottom_left_line, bottom_left_sample, bottom_right_line,
    bottom_right_sample, cell_rows, cell_cols, input ready);
  modport sink (input valid, top_left_line, top_left_sample, top_right_line,
    top_right_sample, bottom_left_line, bottom_left_sample, bottom_right_line,
    bottom_right_sample, cell_rows, cell_cols, output ready);
endinterface

interface gcbci_out_if import gcbci_pkg::*; ();
  logic valid;
  logic ready;
  logic [IdxW-1:0] row_index, col_index;
  logic signed [CoordW-1:0] line_coord, sample_coord;
  logic inside_res;
  logic last;
  modport source (output valid, row_index, col_index, line_coord, sample_coord,
    inside_res, last, input ready);
  modport sink (input valid, row_index, col_index, line_coord, sample_coord,
    inside_res, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/grid_cell_bilinear_coord_interp_core.sv -----
// Bilinear mesh-warp coordinate interpolator, top level.
// Takes one cell item on in_if, emits one point item per cell point on out_if.
// Depends on gcbci_pkg and gcbci_if.
//
// Usage: a cell item (four corner coordinates, rows, cols) is taken on in_if
// when the point sequencer is free. A sequencer then walks the cell row by row
// and issues one point per cycle, unless out_if stalls, into a six-stage pipeline:
//   S1 weights, S2 products of weights and corners (one 32x6 multiply per
//   corner and axis), S3 sum and reciprocal lookup, S4 partial products of the
//   sum and the reciprocal of (rows-1)*(cols-1), S5 quotient estimate,
//   S6 floor correction and bounds test, which is the output register.
// The next cell is taken at the edge that issues the last point of the current
// one, so the sequencer can take a new cell while the points of the current
// one are still in the pipeline.
// A stall on out_if freezes the whole pipeline and the sequencer; nothing is
// lost or repeated. Reset empties the pipeline and sets both image extents to
// 1024. Registers image_lines (addr 0) and image_samples (addr 4) are written
// over the APB port and read back.
`default_nettype none
module grid_cell_bilinear_coord_interp_core import gcbci_pkg::*; #(
  parameter int unsigned GridMax = GridMaxDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  gcbci_in_if.sink              in_if,
  gcbci_out_if.source           out_if,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);
  localparam int unsigned DW  = $clog2(GridMax);          // index width
  localparam int unsigned NW  = DW + DW + 34;             // sum width
  localparam int unsigned PPW = NW + RecipW - RecipLoW + 1; // partial product width
  localparam int unsigned PW  = PPW + RecipLoW + 1;       // full product width
  localparam int unsigned QW  = CoordW + 2;               // quotient estimate width

  // Configuration
  logic [ExtW-1:0] lines_q, samples_q;
  logic            reg_sel;
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q   <= ExtW'(1024);
      samples_q <= ExtW'(1024);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx_e'(reg_sel))
        REG_IMAGE_LINES:   lines_q   <= pwdata[ExtW-1:0];
        REG_IMAGE_SAMPLES: samples_q <= pwdata[ExtW-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_idx_e'(reg_sel))
      REG_IMAGE_LINES:   prdata = 32'(lines_q);
      REG_IMAGE_SAMPLES: prdata = 32'(samples_q);
      default:           prdata = '0;
    endcase
  end

  // ceil(2^RecipShift / d), indexed by the divisor
  logic [RecipW-1:0] rcp_tab [64];
  for (genvar g = 0; g < 64; g++) begin : g_rcp
    localparam longint unsigned Div = (g == 0) ? 1 : g;
    localparam logic [RecipW-1:0] Rcp =
      RecipW'(((64'd1 << RecipShift) + Div - 64'd1) / Div);
    assign rcp_tab[g] = Rcp;
  end

  logic adv;
  assign adv = out_if.ready || !out_if.valid;

  // Sequencer: holds the cell and walks its points
  logic                     busy_q;
  logic signed [31:0]       cl_q [4];
  logic signed [31:0]       cs_q [4];
  logic [DW-1:0]            dr_q, dc_q, i_q, j_q;
  logic [SizeW-1:0]         rows_c, cols_c;
  logic                     last_pt;

  function automatic logic [SizeW-1:0] clamp(input logic [SizeW-1:0] v);
    if (v == '0) return SizeW'(1);
    if (v > SizeW'(GridMax)) return SizeW'(GridMax);
    return v;
  endfunction

  assign rows_c  = clamp(in_if.cell_rows);
  assign cols_c  = clamp(in_if.cell_cols);
  assign last_pt = (i_q == dr_q) && (j_q == dc_q);
  assign in_if.ready = !busy_q || (adv && last_pt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else if (in_if.valid && in_if.ready) begin
      busy_q <= 1'b1;
      i_q    <= '0;
      j_q    <= '0;
    end else if (busy_q && adv) begin
      if (last_pt) begin
        busy_q <= 1'b0;
      end else if (j_q == dc_q) begin
        j_q <= '0;
        i_q <= i_q + DW'(1);
      end else begin
        j_q <= j_q + DW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      cl_q[0] <= in_if.top_left_line;     cs_q[0] <= in_if.top_left_sample;
      cl_q[1] <= in_if.top_right_line;    cs_q[1] <= in_if.top_right_sample;
      cl_q[2] <= in_if.bottom_left_line;  cs_q[2] <= in_if.bottom_left_sample;
      cl_q[3] <= in_if.bottom_right_line; cs_q[3] <= in_if.bottom_right_sample;
      dr_q    <= DW'(rows_c - SizeW'(1));
      dc_q    <= DW'(cols_c - SizeW'(1));
    end
  end

  // S1: weights; a size of one uses divisor one with weights (1,0)
  logic                 v1_q, l1_q;
  logic [DW-1:0]        i1_q, j1_q;
  logic [DW:0]          wr0_q, wr1_q, wc0_q, wc1_q;
  logic [5:0]           den1_q;
  logic signed [31:0]   al1_q [4];
  logic signed [31:0]   as1_q [4];
  logic [DW:0]          drx, dcx;
  assign drx = (dr_q == '0) ? (DW+1)'(1) : (DW+1)'(dr_q);
  assign dcx = (dc_q == '0) ? (DW+1)'(1) : (DW+1)'(dc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= busy_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q  <= last_pt;
      i1_q  <= i_q;
      j1_q  <= j_q;
      wr1_q <= (DW+1)'(i_q);
      wr0_q <= drx - (DW+1)'(i_q);
      wc1_q <= (DW+1)'(j_q);
      wc0_q <= dcx - (DW+1)'(j_q);
      den1_q <= 6'(drx) * 6'(dcx);
      al1_q <= cl_q;
      as1_q <= cs_q;
    end
  end

  // S2: corner products, weight product (at most 49) times corner
  logic                     v2_q, l2_q;
  logic [DW-1:0]            i2_q, j2_q;
  logic [5:0]               den2_q;
  logic signed [NW-1:0]     pl2_q [4];
  logic signed [NW-1:0]     ps2_q [4];
  logic [5:0]               w [4];
  assign w[0] = 6'(wr0_q) * 6'(wc0_q);
  assign w[1] = 6'(wr0_q) * 6'(wc1_q);
  assign w[2] = 6'(wr1_q) * 6'(wc0_q);
  assign w[3] = 6'(wr1_q) * 6'(wc1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l2_q <= l1_q; i2_q <= i1_q; j2_q <= j1_q; den2_q <= den1_q;
      for (int k = 0; k < 4; k++) begin
        pl2_q[k] <= NW'(al1_q[k]) * $signed({1'b0, w[k]});
        ps2_q[k] <= NW'(as1_q[k]) * $signed({1'b0, w[k]});
      end
    end
  end

  // S3: sums, reciprocal lookup
  logic                 v3_q, l3_q;
  logic [DW-1:0]        i3_q, j3_q;
  logic [5:0]           den3_q;
  logic [RecipW-1:0]    rcp3_q;
  logic signed [NW-1:0] nl3_q, ns3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l3_q <= l2_q; i3_q <= i2_q; j3_q <= j2_q; den3_q <= den2_q;
      rcp3_q <= rcp_tab[den2_q];
      nl3_q <= pl2_q[0] + pl2_q[1] + pl2_q[2] + pl2_q[3];
      ns3_q <= ps2_q[0] + ps2_q[1] + ps2_q[2] + ps2_q[3];
    end
  end

  // S4: sum times low and high halves of the reciprocal
  logic                  v4_q, l4_q;
  logic [DW-1:0]         i4_q, j4_q;
  logic [5:0]            den4_q;
  logic signed [NW-1:0]  nl4_q, ns4_q;
  logic signed [PPW-1:0] pll4_q, plh4_q, psl4_q, psh4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l4_q <= l3_q; i4_q <= i3_q; j4_q <= j3_q; den4_q <= den3_q;
      nl4_q <= nl3_q; ns4_q <= ns3_q;
      pll4_q <= PPW'(nl3_q) * $signed({1'b0, rcp3_q[RecipLoW-1:0]});
      plh4_q <= PPW'(nl3_q) * $signed({1'b0, rcp3_q[RecipW-1:RecipLoW]});
      psl4_q <= PPW'(ns3_q) * $signed({1'b0, rcp3_q[RecipLoW-1:0]});
      psh4_q <= PPW'(ns3_q) * $signed({1'b0, rcp3_q[RecipW-1:RecipLoW]});
    end
  end

  // S5: quotient estimate, floored; within one of the true quotient
  logic                 v5_q, l5_q;
  logic [DW-1:0]        i5_q, j5_q;
  logic [5:0]           den5_q;
  logic signed [NW-1:0] nl5_q, ns5_q;
  logic signed [PW-1:0] ql_p, qs_p;
  logic signed [QW-1:0] ql5_q, qs5_q;
  assign ql_p = (PW'(plh4_q) <<< RecipLoW) + PW'(pll4_q);
  assign qs_p = (PW'(psh4_q) <<< RecipLoW) + PW'(psl4_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l5_q <= l4_q; i5_q <= i4_q; j5_q <= j4_q; den5_q <= den4_q;
      nl5_q <= nl4_q; ns5_q <= ns4_q;
      ql5_q <= QW'(ql_p >>> RecipShift);
      qs5_q <= QW'(qs_p >>> RecipShift);
    end
  end

  // S6: step the estimate down or up by one so that the remainder lies in [0, den),
  // then bounds test
  logic signed [NW-1:0] rml, rms;
  logic signed [QW-1:0] lq, sq;
  logic signed [31:0]   lc, sc;
  logic signed [33:0]   liml, lims;
  assign rml  = nl5_q - NW'(ql5_q) * $signed({1'b0, den5_q});
  assign rms  = ns5_q - NW'(qs5_q) * $signed({1'b0, den5_q});
  assign lq   = rml[NW-1] ? ql5_q - QW'(1) :
                (rml >= $signed({1'b0, den5_q})) ? ql5_q + QW'(1) : ql5_q;
  assign sq   = rms[NW-1] ? qs5_q - QW'(1) :
                (rms >= $signed({1'b0, den5_q})) ? qs5_q + QW'(1) : qs5_q;
  assign lc   = lq[31:0];
  assign sc   = sq[31:0];
  assign liml = $signed({1'b0, lines_q, 8'h00}) - 34'sd256;
  assign lims = $signed({1'b0, samples_q, 8'h00}) - 34'sd256;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.valid <= 1'b0;
    else if (adv) out_if.valid <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_if.row_index    <= IdxW'(i5_q);
      out_if.col_index    <= IdxW'(j5_q);
      out_if.line_coord   <= lc;
      out_if.sample_coord <= sc;
      out_if.last         <= l5_q;
      out_if.inside_res   <= !lc[31] && !sc[31] && (34'(lc) < liml) && (34'(sc) < lims);
    end
  end

  // Checks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.line_coord))
    else $error("output item changed under stall");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && busy_q |-> last_pt)
    else $error("new cell taken before last point issued");
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> busy_q && i_q == '0 && j_q == '0)
    else $error("sequencer did not restart at origin");
endmodule
`default_nettype wire

// ----- sim/grid_cell_bilinear_coord_interp_check.sv -----
// Checker for the grid cell bilinear coordinate interpolator: watches the cell
// and point channels and the register port, predicts every point and compares.
// Depends on gcbci_pkg and gcbci_if.
`default_nettype none
module grid_cell_bilinear_coord_interp_check import gcbci_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  gcbci_in_if                   cell_mon,
  gcbci_out_if                  point_mon,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic             pready,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output int                    fail_cnt_o,
  output int                    pending_o
);
  typedef struct packed {
    logic [IdxW-1:0]          row;
    logic [IdxW-1:0]          col;
    logic signed [CoordW-1:0] line;
    logic signed [CoordW-1:0] samp;
    logic                     in_bnd;
    logic                     last;
  } point_t;

  point_t          point_q[$];
  logic [ExtW-1:0] lines_ext, samples_ext;
  int              fails;

  assign fail_cnt_o = fails;
  assign pending_o  = point_q.size();

  function automatic int unsigned size_clamp(input logic [SizeW-1:0] s);
    if (s == 0) return 1;
    if (s > GridMaxDefault) return GridMaxDefault;
    return s;
  endfunction

  // Exact weighted sum of the corners, floored to the coordinate grid.
  function automatic longint blend(input longint c00, c01, c10, c11,
                                   input longint i, j, dr, dc);
    longint num, den, q;
    num = (dr - i) * (dc - j) * c00 + (dr - i) * j * c01
        + i * (dc - j) * c10 + i * j * c11;
    den = dr * dc;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  task automatic expand_cell();
    int unsigned rows, cols;
    longint dr, dc, lc, sc, lim_l, lim_s;
    point_t p;
    rows  = size_clamp(cell_mon.cell_rows);
    cols  = size_clamp(cell_mon.cell_cols);
    dr    = (rows > 1) ? rows - 1 : 1;
    dc    = (cols > 1) ? cols - 1 : 1;
    lim_l = (longint'(lines_ext) - 1) * 256;
    lim_s = (longint'(samples_ext) - 1) * 256;
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        lc = blend(cell_mon.top_left_line, cell_mon.top_right_line,
                   cell_mon.bottom_left_line, cell_mon.bottom_right_line, i, j, dr, dc);
        sc = blend(cell_mon.top_left_sample, cell_mon.top_right_sample,
                   cell_mon.bottom_left_sample, cell_mon.bottom_right_sample, i, j, dr, dc);
        p.row    = i[IdxW-1:0];
        p.col    = j[IdxW-1:0];
        p.line   = lc[CoordW-1:0];
        p.samp   = sc[CoordW-1:0];
        p.in_bnd = lc >= 0 && lc < lim_l && sc >= 0 && sc < lim_s;
        p.last   = (i == rows - 1) && (j == cols - 1);
        point_q = {point_q, p};
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, want);
    fails++;
    if (fails <= 60)
      $display("MISMATCH %s: got %0h expected %0h (point %0d pending)", what, got, want,
               point_q.size());
  endtask

  task automatic compare_point();
    point_t e;
    if (point_q.size() == 0) begin
      report("unexpected point", {point_mon.row_index, point_mon.col_index}, 0);
      return;
    end
    e = point_q.pop_front();
    if (point_mon.row_index !== e.row) report("row_index", point_mon.row_index, e.row);
    if (point_mon.col_index !== e.col) report("col_index", point_mon.col_index, e.col);
    if (point_mon.line_coord !== e.line) report("line_coord", point_mon.line_coord, e.line);
    if (point_mon.sample_coord !== e.samp)
      report("sample_coord", point_mon.sample_coord, e.samp);
    if (point_mon.inside_res !== e.in_bnd) report("inside_res", point_mon.inside_res, e.in_bnd);
    if (point_mon.last !== e.last) report("last", point_mon.last, e.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_ext   <= ExtW'(1024);
      samples_ext <= ExtW'(1024);
      fails = 0;
      point_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[AddrW-1:2] == REG_IMAGE_LINES) lines_ext <= pwdata[ExtW-1:0];
        else if (paddr[AddrW-1:2] == REG_IMAGE_SAMPLES) samples_ext <= pwdata[ExtW-1:0];
      end
      if (point_mon.valid && point_mon.ready) compare_point();
      if (cell_mon.valid && cell_mon.ready) expand_cell();
    end
  end
endmodule
`default_nettype wire

// ----- sim/grid_cell_bilinear_coord_interp_core_test.sv -----
// Testbench top for the grid cell bilinear coordinate interpolator: drives cells
// and register writes, stalls the point side, and gives the verdict.
// Depends on gcbci_pkg, gcbci_if, the core and grid_cell_bilinear_coord_interp_check.
`default_nettype none
module grid_cell_bilinear_coord_interp_core_test;
  import gcbci_pkg::*;

  localparam int CycleLimit = 700000;

  logic             clk;
  logic             rst_n;
  logic             psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             quiet_src, quiet_snk, hold_points;
  int               fail_cnt, pending, cyc;
  int               cur_lines, cur_samples;

  gcbci_in_if  cell_ch ();
  gcbci_out_if point_ch ();

  grid_cell_bilinear_coord_interp_core dut (
    .clk_i(clk), .rst_ni(rst_n), .in_if(cell_ch), .out_if(point_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  grid_cell_bilinear_coord_interp_check chk (
    .clk_i(clk), .rst_ni(rst_n), .cell_mon(cell_ch), .point_mon(point_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cyc = 0;
    rst_n = 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    cell_ch.valid <= 1'b0;
    cell_ch.top_left_line <= '0; cell_ch.top_left_sample <= '0;
    cell_ch.top_right_line <= '0; cell_ch.top_right_sample <= '0;
    cell_ch.bottom_left_line <= '0; cell_ch.bottom_left_sample <= '0;
    cell_ch.bottom_right_line <= '0; cell_ch.bottom_right_sample <= '0;
    cell_ch.cell_rows <= '0; cell_ch.cell_cols <= '0;
    point_ch.ready <= 1'b0;
    quiet_src = 1'b0; quiet_snk = 1'b0; hold_points <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Point side: random gap per item, plus the long hold-off when requested.
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      w = quiet_snk ? 0 : $urandom_range(0, 5);
      repeat (w) begin
        point_ch.ready <= 1'b0;
        @(posedge clk);
      end
      point_ch.ready <= !hold_points;
      @(posedge clk);
      while (!(point_ch.valid && point_ch.ready)) begin
        point_ch.ready <= !hold_points;
        @(posedge clk);
      end
    end
  end

  task automatic long_hold();
    hold_points <= 1'b1;
    repeat (400) @(posedge clk);
    hold_points <= 1'b0;
  endtask

  task automatic reg_write(input reg_idx_e idx, input int unsigned val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_IMAGE_LINES) cur_lines = val & 32'h7FFFFF;
    else cur_samples = val & 32'h7FFFFF;
    @(posedge clk);
  endtask

  task automatic send_cell(input logic [31:0] c[8], input logic [3:0] r, input logic [3:0] k);
    int w;
    w = quiet_src ? 0 : $urandom_range(0, 5);
    if (w > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.top_left_line <= c[0];     cell_ch.top_left_sample <= c[1];
    cell_ch.top_right_line <= c[2];    cell_ch.top_right_sample <= c[3];
    cell_ch.bottom_left_line <= c[4];  cell_ch.bottom_left_sample <= c[5];
    cell_ch.bottom_right_line <= c[6]; cell_ch.bottom_right_sample <= c[7];
    cell_ch.cell_rows <= r; cell_ch.cell_cols <= k;
    @(posedge clk);
    while (!cell_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted point has come out.
  task automatic drain();
    cell_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(input int ext);
    int unsigned span;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      default: begin
        span = (ext > 60000) ? 32'h00F00000 : ext * 256 + 1024;
        return $urandom_range(0, span) - 512;
      end
    endcase
  endfunction

  function automatic logic [3:0] pick_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(1, 8);
  endfunction

  task automatic random_cells(input int n);
    logic [31:0] c[8];
    for (int m = 0; m < n; m++) begin
      if (m % 20 == 0) begin
        quiet_src = ($urandom_range(0, 3) == 0);
        quiet_snk = ($urandom_range(0, 3) == 0);
      end
      for (int k = 0; k < 8; k++) c[k] = pick_coord((k % 2 == 0) ? cur_lines : cur_samples);
      send_cell(c, pick_size(), pick_size());
    end
  endtask

  initial begin
    logic [31:0] c[8];
    int unsigned lset[6];
    int unsigned sset[6];
    cur_lines = 1024;
    cur_samples = 1024;
    @(posedge rst_n);
    @(posedge clk);

    // Directed cells: corner extremes, size limits and floor on negatives.
    foreach (c[k]) c[k] = 32'h7FFFFFFF;
    send_cell(c, 4'd8, 4'd8);
    foreach (c[k]) c[k] = 32'h80000000;
    send_cell(c, 4'd8, 4'd8);
    foreach (c[k]) c[k] = (k < 4) ? 32'h7FFFFFFF : 32'h80000000;
    send_cell(c, 4'd8, 4'd7);
    foreach (c[k]) c[k] = (k % 4 < 2) ? 32'h80000000 : 32'h7FFFFFFF;
    send_cell(c, 4'd3, 4'd8);
    foreach (c[k]) c[k] = (k % 3 == 0) ? 32'hFFFFFFFF : 32'h00000000;
    send_cell(c, 4'd4, 4'd4);
    foreach (c[k]) c[k] = -(k * 37 + 1);
    send_cell(c, 4'd7, 4'd6);
    send_cell(c, 4'd0, 4'd5);
    send_cell(c, 4'd5, 4'd0);
    send_cell(c, 4'd0, 4'd0);
    send_cell(c, 4'd15, 4'd9);
    send_cell(c, 4'd1, 4'd1);
    foreach (c[k]) c[k] = (k % 2 == 0) ? 32'd0 : 32'd261888;
    send_cell(c, 4'd1, 4'd8);
    send_cell(c, 4'd8, 4'd1);
    foreach (c[k]) c[k] = (k < 2) ? -32'sd1 : 32'd261889;
    send_cell(c, 4'd2, 4'd2);
    foreach (c[k]) c[k] = 32'd261887 + (k % 3);
    send_cell(c, 4'd3, 4'd3);
    foreach (c[k]) c[k] = $urandom;
    send_cell(c, 4'd6, 4'd5);
    drain();

    lset = '{8388607, 0, 1, 2, 37, 1024};
    sset = '{8388607, 1, 0, 3, 50, 1024};
    foreach (lset[p]) begin
      reg_write(REG_IMAGE_LINES, (p == 4) ? $urandom_range(2, 64) | 32'hFF800000 : lset[p]);
      reg_write(REG_IMAGE_SAMPLES, (p == 4) ? $urandom_range(2, 64) : sset[p]);
      if (p == 2) fork
        long_hold();
      join_none
      random_cells(44);
      drain();
    end

    if (fail_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/gcbci_pkg.sv
hdl/gcbci_if.sv
hdl/grid_cell_bilinear_coord_interp_core.sv
sim/grid_cell_bilinear_coord_interp_check.sv
sim/grid_cell_bilinear_coord_interp_core_test.sv
